@@ hw/rtl/aof_pkg.sv @@
// Shared types, constants and helpers for the 3x3 average outward flux core.
// Used by the core, its line memory and its flux arithmetic.
`default_nettype none

package aof_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int ROW_LIMIT   = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(ROW_LIMIT);
    localparam int DIM_BITS    = 11;
    localparam int CFG_IDX_BITS = 2;
    localparam int FLUX_BITS   = 17;

    // axial sum of four samples, diagonal sum of eight samples
    localparam int AXIAL_BITS  = SAMPLE_BITS + 2;
    localparam int DIAG_BITS   = SAMPLE_BITS + 3;
    localparam int SUM_BITS    = 35;
    localparam int AXIAL_SHIFT = 15;
    localparam int OUT_SHIFT   = 18;

    localparam logic signed [15:0] DIAG_Q15 = 16'sd23170;
    localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) <<< (OUT_SHIFT - 1);

    localparam logic [DIM_BITS-1:0] DIM_MIN        = DIM_BITS'(3);
    localparam logic [DIM_BITS-1:0] WIDTH_MAX      = DIM_BITS'(MAX_WIDTH);
    localparam logic [DIM_BITS-1:0] HEIGHT_MAX     = DIM_BITS'(ROW_LIMIT);
    localparam logic [DIM_BITS-1:0] WIDTH_DEFAULT  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] HEIGHT_DEFAULT = DIM_BITS'(480);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } t_cfg_index;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // one line memory word: {top_x, top_y, mid_x, mid_y}
    typedef logic [4*SAMPLE_BITS-1:0] t_line_word;

    typedef struct packed {
        logic ld_sum;
        logic ld_prod;
        logic ld_out;
    } t_flux_ctrl;

    function automatic logic [DIM_BITS-1:0] clamp_dim(
        input logic [DIM_BITS-1:0] v,
        input logic [DIM_BITS-1:0] hi
    );
        logic [DIM_BITS-1:0] r;
        if (v < DIM_MIN) begin
            r = DIM_MIN;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/average_outward_flux_3x3_core.sv @@
// Average outward flux over a 3x3 window, streamed in raster order.
// Uses aof_pkg, aof_line_mem and aof_flux.
//
// The core takes one gradient pair per clock cycle and keeps that rate
// indefinitely while the output is not stalled: each pixel costs one read
// and one write of the line memory, which sit in different pipeline stages
// and run in the same cycle. A result for an interior center pixel (c, r)
// leaves the pipeline after pixel (c+1, r+1) is accepted; border pixels
// produce no result. Output back-pressure stalls the stages only as far as
// there are no bubbles to absorb it. Width and height are taken clamped to
// 3..1024; write them only while the pipeline is empty. A write takes effect
// at the next pixel and leaves the raster counters alone. The line memory has
// no reset; the first two rows of a frame fill it before any result reads it.
`default_nettype none

module average_outward_flux_3x3_core
    import aof_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [DIM_BITS-1:0]     i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_grad_x,
    input  wire logic signed [SAMPLE_BITS-1:0] i_grad_y,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [FLUX_BITS-1:0]  o_flux_value,
    output logic [COL_BITS-1:0]          o_center_col,
    output logic [ROW_BITS-1:0]          o_center_row,
    output logic                         o_frame_last
);

    logic [DIM_BITS-1:0] r_width;
    logic [DIM_BITS-1:0] r_height;
    logic [DIM_BITS-1:0] w_lim;
    logic [DIM_BITS-1:0] h_lim;

    logic [COL_BITS-1:0] r_col_cnt;
    logic [ROW_BITS-1:0] r_row_cnt;
    logic [COL_BITS-1:0] n_col_cnt;
    logic [ROW_BITS-1:0] n_row_cnt;
    logic [COL_BITS-1:0] cur_col;
    logic [ROW_BITS-1:0] cur_row;

    // stage 1: line memory read in flight
    logic                r_v1;
    logic [COL_BITS-1:0] r_col1;
    logic [ROW_BITS-1:0] r_row1;
    t_sample             r_x1;
    t_sample             r_y1;
    logic                r_emit1;
    logic                r_last1;

    // stage 2..5 metadata
    logic                r_v2;
    logic [COL_BITS-1:0] r_col2;
    logic [ROW_BITS-1:0] r_row2;
    logic                r_last2;
    logic                r_v3;
    logic [COL_BITS-1:0] r_col3;
    logic [ROW_BITS-1:0] r_row3;
    logic                r_last3;
    logic                r_v4;
    logic [COL_BITS-1:0] r_col4;
    logic [ROW_BITS-1:0] r_row4;
    logic                r_last4;
    logic                r_v5;
    logic [COL_BITS-1:0] r_col5;
    logic [ROW_BITS-1:0] r_row5;
    logic                r_last5;

    t_sample r_win_x [0:2][0:2];
    t_sample r_win_y [0:2][0:2];

    logic       accept;
    logic       ld2;
    logic       ld3;
    logic       ld4;
    logic       ld5;
    logic       free1;
    logic       free2;
    logic       free3;
    logic       free4;
    t_flux_ctrl flux_ctrl;
    t_line_word rd_word;
    t_line_word wr_word;

    assign w_lim = clamp_dim(r_width, WIDTH_MAX);
    assign h_lim = clamp_dim(r_height, HEIGHT_MAX);

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_DEFAULT;
            r_height <= HEIGHT_DEFAULT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // raster position of the incoming pixel and of the one after it
    always_comb begin
        logic [DIM_BITS-1:0] row_a;
        logic [DIM_BITS-1:0] col_p1;
        logic [DIM_BITS-1:0] row_p1;
        row_a = DIM_BITS'(r_row_cnt);
        cur_col = r_col_cnt;
        if (DIM_BITS'(r_col_cnt) >= w_lim) begin
            cur_col = '0;
            row_a   = DIM_BITS'(r_row_cnt) + DIM_BITS'(1);
        end
        cur_row = (row_a >= h_lim) ? '0 : row_a[ROW_BITS-1:0];

        col_p1 = DIM_BITS'(cur_col) + DIM_BITS'(1);
        row_p1 = DIM_BITS'(cur_row) + DIM_BITS'(1);
        if (col_p1 >= w_lim) begin
            n_col_cnt = '0;
            n_row_cnt = (row_p1 >= h_lim) ? '0 : row_p1[ROW_BITS-1:0];
        end else begin
            n_col_cnt = col_p1[COL_BITS-1:0];
            n_row_cnt = cur_row;
        end
    end

    // pipeline advance, back from the output register
    assign ld5   = r_v4 && (!r_v5 || i_out_ready);
    assign free4 = !r_v4 || ld5;
    assign ld4   = r_v3 && free4;
    assign free3 = !r_v3 || ld4;
    assign ld3   = r_v2 && free3;
    assign free2 = !r_v2 || ld3;
    assign ld2   = r_v1 && free2;
    assign free1 = !r_v1 || ld2;
    assign o_in_ready = free1;
    assign accept = i_in_valid && free1;

    assign flux_ctrl.ld_sum  = ld3;
    assign flux_ctrl.ld_prod = ld4;
    assign flux_ctrl.ld_out  = ld5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
        end else begin
            if (accept) begin
                r_col_cnt <= n_col_cnt;
                r_row_cnt <= n_row_cnt;
            end
            r_v1 <= accept || (r_v1 && !ld2);
            // a border pixel updates the window and then drops out
            if (ld2) begin
                r_v2 <= r_emit1;
            end else if (ld3) begin
                r_v2 <= 1'b0;
            end
            r_v3 <= ld3 || (r_v3 && !ld4);
            r_v4 <= ld4 || (r_v4 && !ld5);
            r_v5 <= ld5 || (r_v5 && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col1  <= cur_col;
            r_row1  <= cur_row;
            r_x1    <= i_grad_x;
            r_y1    <= i_grad_y;
            r_emit1 <= (cur_col >= COL_BITS'(2)) && (cur_row >= ROW_BITS'(2));
            r_last1 <= (DIM_BITS'(cur_col) == w_lim - DIM_BITS'(1))
                    && (DIM_BITS'(cur_row) == h_lim - DIM_BITS'(1));
        end
        if (ld2) begin
            r_col2  <= r_col1 - COL_BITS'(1);
            r_row2  <= r_row1 - ROW_BITS'(1);
            r_last2 <= r_last1;
        end
        if (ld3) begin
            r_col3  <= r_col2;
            r_row3  <= r_row2;
            r_last3 <= r_last2;
        end
        if (ld4) begin
            r_col4  <= r_col3;
            r_row4  <= r_row3;
            r_last4 <= r_last3;
        end
        if (ld5) begin
            r_col5  <= r_col4;
            r_row5  <= r_row4;
            r_last5 <= r_last4;
        end
    end

    // Read at the new pixel's column while stage 1 writes back its own column.
    // Consecutive pixels never share a column, so the two never collide.
    assign wr_word = {rd_word[2*SAMPLE_BITS-1:0], r_x1, r_y1};

    aof_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (cur_col),
        .o_rd_data (rd_word),
        .i_wr_en   (ld2),
        .i_wr_addr (r_col1),
        .i_wr_data (wr_word)
    );

    // shift the windows left and drop in the new column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win_x[r][c] <= '0;
                    r_win_y[r][c] <= '0;
                end
            end
        end else if (ld2) begin
            for (int r = 0; r < 3; r++) begin
                r_win_x[r][0] <= r_win_x[r][1];
                r_win_x[r][1] <= r_win_x[r][2];
                r_win_y[r][0] <= r_win_y[r][1];
                r_win_y[r][1] <= r_win_y[r][2];
            end
            r_win_x[0][2] <= rd_word[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
            r_win_y[0][2] <= rd_word[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
            r_win_x[1][2] <= rd_word[2*SAMPLE_BITS-1:SAMPLE_BITS];
            r_win_y[1][2] <= rd_word[SAMPLE_BITS-1:0];
            r_win_x[2][2] <= r_x1;
            r_win_y[2][2] <= r_y1;
        end
    end

    aof_flux u_flux (
        .i_clk   (i_clk),
        .i_ctrl  (flux_ctrl),
        .i_win_x (r_win_x),
        .i_win_y (r_win_y),
        .o_flux  (o_flux_value)
    );

    assign o_out_valid  = r_v5;
    assign o_center_col = r_col5;
    assign o_center_row = r_row5;
    assign o_frame_last = r_last5;

endmodule

`default_nettype wire

@@ hw/rtl/aof_line_mem.sv @@
// Line memory of the flux core: both previous rows of both gradient channels,
// one word per column. Synchronous read into a register. Uses aof_pkg.
`default_nettype none

module aof_line_mem
    import aof_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rd_en,
    input  wire logic [COL_BITS-1:0] i_rd_addr,
    output t_line_word               o_rd_data,
    input  wire logic                i_wr_en,
    input  wire logic [COL_BITS-1:0] i_wr_addr,
    input  wire t_line_word          i_wr_data
);

    t_line_word r_mem [0:MAX_WIDTH-1];
    t_line_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold the read word while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hw/rtl/aof_flux.sv @@
// Flux arithmetic of the 3x3 core: weighted neighbor sums, the diagonal
// product and the rounded divide by 8. Three register stages. Uses aof_pkg.
`default_nettype none

module aof_flux
    import aof_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire t_flux_ctrl             i_ctrl,
    input  wire t_sample                i_win_x [0:2][0:2],
    input  wire t_sample                i_win_y [0:2][0:2],
    output logic signed [FLUX_BITS-1:0] o_flux
);

    logic signed [AXIAL_BITS-1:0] n_axial;
    logic signed [DIAG_BITS-1:0]  n_diag;
    logic signed [AXIAL_BITS-1:0] r_axial;
    logic signed [DIAG_BITS-1:0]  r_diag;
    logic signed [AXIAL_BITS-1:0] r_axial_d;
    logic signed [SUM_BITS-1:0]   r_mult;
    logic signed [SUM_BITS-1:0]   n_total;
    logic signed [FLUX_BITS-1:0]  r_flux;

    // row 0 is the top of the window, column 2 the newest column
    always_comb begin
        n_axial = AXIAL_BITS'(i_win_x[1][2]) - AXIAL_BITS'(i_win_x[1][0])
                + AXIAL_BITS'(i_win_y[2][1]) - AXIAL_BITS'(i_win_y[0][1]);
        n_diag  = DIAG_BITS'(i_win_x[2][2]) + DIAG_BITS'(i_win_y[2][2])
                + DIAG_BITS'(i_win_y[2][0]) - DIAG_BITS'(i_win_x[2][0])
                + DIAG_BITS'(i_win_x[0][2]) - DIAG_BITS'(i_win_y[0][2])
                - DIAG_BITS'(i_win_x[0][0]) - DIAG_BITS'(i_win_y[0][0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_sum) begin
            r_axial <= n_axial;
            r_diag  <= n_diag;
        end
        if (i_ctrl.ld_prod) begin
            r_axial_d <= r_axial;
            r_mult    <= SUM_BITS'(r_diag) * SUM_BITS'(DIAG_Q15);
        end
        if (i_ctrl.ld_out) begin
            r_flux <= n_total[SUM_BITS-1:OUT_SHIFT];
        end
    end

    // The bounded window keeps the quotient well inside 17 bits, so taking
    // the upper bits is a floor divide that never needs saturation.
    always_comb begin
        n_total = (SUM_BITS'(r_axial_d) <<< AXIAL_SHIFT) + r_mult + ROUND_HALF;
    end

    assign o_flux = r_flux;

endmodule

`default_nettype wire

@@ hw/rtl/aof_checker.sv @@
// Port-level checks for the flux core, bound to its top level.
// Uses aof_pkg for port widths.
`default_nettype none

module aof_checker
    import aof_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_ready,
    input wire logic signed [FLUX_BITS-1:0] o_flux_value,
    input wire logic [COL_BITS-1:0]     o_center_col,
    input wire logic [ROW_BITS-1:0]     o_center_row,
    input wire logic                    o_frame_last
);

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a result is never for a pixel in the first row or the first column
    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_center_col != '0) && (o_center_row != '0))
        else $error("result for a border pixel");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transaction");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_flux_value) && $stable(o_center_col)
            && $stable(o_center_row) && $stable(o_frame_last))
        else $error("stalled result changed");

endmodule

bind average_outward_flux_3x3_core aof_checker u_aof_checker (.*);

`default_nettype wire
